// ===== rtl/mphq_pkg.sv =====
package mphq_pkg;

  // transaction opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_CALIB = 2'd2;

  // configuration register indexes
  localparam logic CFG_DRY_LEVEL = 1'b0;
  localparam logic CFG_WET_LEVEL = 1'b1;

  // calibration reset values
  localparam int DRY_RESET = 3000;
  localparam int WET_RESET = 1200;

  // percentage scale and width
  localparam int PERCENT_SCALE = 100;
  localparam int PERCENT_W     = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/mphq_store.sv =====
module mphq_store #(
  parameter int DEPTH  = 16,
  parameter int IDX_W  = 4
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [IDX_W-1:0]                    wr_addr,
  input  logic [mphq_pkg::PERCENT_W-1:0]      wr_data,
  input  logic                                rd_en,
  input  logic [IDX_W-1:0]                    rd_addr,
  output logic [mphq_pkg::PERCENT_W-1:0]      rd_data
);

  logic [mphq_pkg::PERCENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/mphq_divider.sv =====
module mphq_divider #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic [SAMPLE_BITS+mphq_pkg::PERCENT_W-1:0] numer,
  input  logic [SAMPLE_BITS-1:0]                   denom,
  output logic                                     done,
  output logic [mphq_pkg::PERCENT_W-1:0]           quotient
);

  localparam int NUM_W = SAMPLE_BITS + mphq_pkg::PERCENT_W;
  localparam int CNT_W = $clog2(mphq_pkg::PERCENT_W);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             fits;

  // restoring division, one quotient bit per cycle, msb first
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= numer;
      dsh      <= NUM_W'(denom) << (mphq_pkg::PERCENT_W - 1);
      cnt      <= CNT_W'(mphq_pkg::PERCENT_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[mphq_pkg::PERCENT_W-2:0], fits};
      dsh      <= dsh >> 1;
      cnt      <= cnt - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/moisture_percent_history_queue_unit.sv =====
// moisture percent history queue
// input channel (in_valid / in_stall): one transaction carries an opcode and a
// raw converter sample. a push clamps the sample between the two calibration
// levels, maps it to 0..100 percent (dry level gives 0, wet level gives 100)
// and appends it to a ring of QUEUE_DEPTH entries, overwriting the oldest
// entry when full. a pop returns the oldest stored percentage.
// output channel (out_valid / out_stall): exactly one result per input
// transaction, carrying status, percent and the fill level after the item.
// configuration: cfg_we writes dry_level (index 0) or wet_level (index 1);
// write only while no transaction is in flight.
// a pop or a rejected push goes from accept straight to the commit step;
// a normal push passes through the clamp, load, iterative divide and commit
// steps. one item is worked on at a time, so no new transaction is accepted
// until the previous one has committed.
// the result sits in an output register: the next item is accepted while a
// result waits, but a finished item does not commit until the output
// register is free, so a stalled receiver holds the block in its last step.
// reset (synchronous) empties the queue and restores default levels; store
// contents are not cleared, only the indexes and the count.
module moisture_percent_history_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic                                         opcode,
  input  logic [SAMPLE_BITS-1:0]                       raw_sample,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [1:0]                                   status,
  output logic [mphq_pkg::PERCENT_W-1:0]               percent,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]             fill_level,
  input  logic                                         cfg_we,
  input  logic                                         cfg_index,
  input  logic [SAMPLE_BITS-1:0]                       cfg_data
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_W  = SAMPLE_BITS + mphq_pkg::PERCENT_W;

  mphq_pkg::state_t state, state_next;

  // calibration registers
  logic [SAMPLE_BITS-1:0] dry_level;
  logic [SAMPLE_BITS-1:0] wet_level;

  // queue pointers
  logic [IDX_W-1:0]  write_index;
  logic [IDX_W-1:0]  read_index;
  logic [FILL_W-1:0] entry_count;

  // captured transaction
  logic                   opcode_r;
  logic [SAMPLE_BITS-1:0] raw_r;
  logic [1:0]             status_r;

  // clamp and scale datapath
  logic [SAMPLE_BITS-1:0] diff_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic                   dry_gt;
  logic [SAMPLE_BITS-1:0] lo_level;
  logic [SAMPLE_BITS-1:0] hi_level;
  logic [SAMPLE_BITS-1:0] raw_clamped;
  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS-1:0] den;
  logic [NUM_W-1:0]       numer;

  // fsm outputs
  logic accept;
  logic div_start;
  logic commit;
  logic out_free;

  // divider and store
  logic                           div_done;
  logic [mphq_pkg::PERCENT_W-1:0] quotient;
  logic [mphq_pkg::PERCENT_W-1:0] rd_data;
  logic                           store_we;

  logic queue_full;
  logic [IDX_W-1:0] write_index_next;
  logic [IDX_W-1:0] read_index_next;

  assign out_free   = !out_valid || !out_stall;
  assign queue_full = (entry_count == FILL_W'(QUEUE_DEPTH));

  // ring wrap
  assign write_index_next = (write_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : write_index + IDX_W'(1);
  assign read_index_next  = (read_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : read_index + IDX_W'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dry_level <= SAMPLE_BITS'(mphq_pkg::DRY_RESET);
      wet_level <= SAMPLE_BITS'(mphq_pkg::WET_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mphq_pkg::CFG_DRY_LEVEL: dry_level <= cfg_data;
        mphq_pkg::CFG_WET_LEVEL: wet_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mphq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (opcode == mphq_pkg::OP_POP || dry_level == wet_level) begin
            state_next = mphq_pkg::ST_FINISH;
          end else begin
            state_next = mphq_pkg::ST_PREP;
          end
        end
      end
      mphq_pkg::ST_PREP:   state_next = mphq_pkg::ST_LOAD;
      mphq_pkg::ST_LOAD:   state_next = mphq_pkg::ST_DIVIDE;
      mphq_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = mphq_pkg::ST_FINISH;
        end
      end
      mphq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = mphq_pkg::ST_IDLE;
        end
      end
      default: state_next = mphq_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    unique case (state)
      mphq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      mphq_pkg::ST_LOAD:   div_start = 1'b1;
      mphq_pkg::ST_FINISH: commit    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mphq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the transaction and classify it up front
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r <= opcode;
      raw_r    <= raw_sample;
      if (opcode == mphq_pkg::OP_POP) begin
        status_r <= (entry_count == '0) ? mphq_pkg::STATUS_EMPTY : mphq_pkg::STATUS_OK;
      end else begin
        status_r <= (dry_level == wet_level) ? mphq_pkg::STATUS_CALIB : mphq_pkg::STATUS_OK;
      end
    end
  end

  // clamp into the calibrated span and take distance from the dry level
  assign dry_gt      = (dry_level > wet_level);
  assign lo_level    = dry_gt ? wet_level : dry_level;
  assign hi_level    = dry_gt ? dry_level : wet_level;
  assign raw_clamped = (raw_r < lo_level) ? lo_level :
                       (raw_r > hi_level) ? hi_level : raw_r;
  assign diff        = dry_gt ? (dry_level - raw_clamped) : (raw_clamped - dry_level);
  assign den         = dry_gt ? (dry_level - wet_level) : (wet_level - dry_level);

  always_ff @(posedge clk) begin
    if (state == mphq_pkg::ST_PREP) begin
      diff_r <= diff;
      den_r  <= den;
    end
  end

  // constant multiply by the full scale, quotient never exceeds it
  assign numer = NUM_W'(diff_r) * NUM_W'(mphq_pkg::PERCENT_SCALE);

  mphq_divider #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // only push commits write; pop read is issued at accept, one item at a
  // time so a read never overlaps a write to the same entry
  assign store_we = commit && opcode_r == mphq_pkg::OP_PUSH
                    && status_r == mphq_pkg::STATUS_OK;

  mphq_store #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (write_index),
    .wr_data (quotient),
    .rd_en   (accept && opcode == mphq_pkg::OP_POP),
    .rd_addr (read_index),
    .rd_data (rd_data)
  );

  // queue pointer update at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      entry_count <= '0;
    end else if (commit && status_r == mphq_pkg::STATUS_OK) begin
      if (opcode_r == mphq_pkg::OP_PUSH) begin
        write_index <= write_index_next;
        if (queue_full) begin
          read_index <= read_index_next;
        end else begin
          entry_count <= entry_count + FILL_W'(1);
        end
      end else begin
        read_index  <= read_index_next;
        entry_count <= entry_count - FILL_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status <= status_r;
      if (opcode_r == mphq_pkg::OP_POP && status_r == mphq_pkg::STATUS_OK) begin
        percent     <= rd_data;
        fill_level  <= entry_count - FILL_W'(1);
      end else if (opcode_r == mphq_pkg::OP_PUSH && status_r == mphq_pkg::STATUS_OK) begin
        percent     <= '0;
        fill_level  <= queue_full ? entry_count : entry_count + FILL_W'(1);
      end else begin
        percent     <= '0;
        fill_level  <= entry_count;
      end
    end
  end

endmodule

// ===== bench/moisture_history_monitor.sv =====
`timescale 1ns / 100ps

// watches both channels and the calibration writes, predicts every result
// and compares it with what the block returns
module moisture_history_monitor #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [SAMPLE_BITS-1:0]               raw_sample,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [1:0]                           status,
  input  logic [mphq_pkg::PERCENT_W-1:0]       percent,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     fill_level,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [SAMPLE_BITS-1:0]               cfg_data,
  output int                                   mismatch_count,
  output int                                   replies_owed
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct {
    logic [1:0]                     status;
    logic [mphq_pkg::PERCENT_W-1:0] percent;
    logic [FILL_W-1:0]              fill_level;
  } history_reply_t;

  history_reply_t                 predicted_replies[$];
  logic [mphq_pkg::PERCENT_W-1:0] stored_percent[QUEUE_DEPTH];
  int unsigned                    oldest_slot;
  int unsigned                    next_slot;
  int unsigned                    held_entries;
  logic [SAMPLE_BITS-1:0]         dry_copy;
  logic [SAMPLE_BITS-1:0]         wet_copy;
  history_reply_t                 want;
  history_reply_t                 got;

  // clamp into the calibrated span, then scale linearly, truncating
  function automatic int unsigned calibrated_percent(input int unsigned raw,
                                                     input int unsigned dry,
                                                     input int unsigned wet);
    int unsigned lo;
    int unsigned hi;
    int unsigned level;
    int unsigned pct;
    lo = (dry < wet) ? dry : wet;
    hi = (dry < wet) ? wet : dry;
    level = (raw < lo) ? lo : ((raw > hi) ? hi : raw);
    if (dry > wet) pct = (dry - level) * mphq_pkg::PERCENT_SCALE / (dry - wet);
    else pct = (level - dry) * mphq_pkg::PERCENT_SCALE / (wet - dry);
    return (pct > mphq_pkg::PERCENT_SCALE) ? mphq_pkg::PERCENT_SCALE : pct;
  endfunction

  function automatic void flag_failure(input string msg);
    if (mismatch_count < 10) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      predicted_replies.delete();
      oldest_slot = 0;
      next_slot = 0;
      held_entries = 0;
      dry_copy = SAMPLE_BITS'(mphq_pkg::DRY_RESET);
      wet_copy = SAMPLE_BITS'(mphq_pkg::WET_RESET);
      replies_owed <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mphq_pkg::CFG_DRY_LEVEL) dry_copy = cfg_data;
        else wet_copy = cfg_data;
      end

      if (out_valid && !out_stall) begin
        got.status = status;
        got.percent = percent;
        got.fill_level = fill_level;
        if (predicted_replies.size() == 0) begin
          flag_failure($sformatf("result with none expected: status %0d percent %0d fill %0d",
                                 got.status, got.percent, got.fill_level));
        end else begin
          want = predicted_replies.pop_front();
          if (want.status !== got.status || want.percent !== got.percent ||
              want.fill_level !== got.fill_level) begin
            flag_failure($sformatf({"mismatch: expected status %0d percent %0d fill %0d,",
                                    " got status %0d percent %0d fill %0d"},
                                   want.status, want.percent, want.fill_level,
                                   got.status, got.percent, got.fill_level));
          end
        end
      end

      if (in_valid && !in_stall) begin
        want.status = mphq_pkg::STATUS_OK;
        want.percent = '0;
        if (opcode == mphq_pkg::OP_PUSH) begin
          if (dry_copy == wet_copy) begin
            want.status = mphq_pkg::STATUS_CALIB;
          end else begin
            // full ring drops its oldest entry
            if (held_entries == QUEUE_DEPTH) oldest_slot = (oldest_slot + 1) % QUEUE_DEPTH;
            else held_entries++;
            stored_percent[next_slot] = mphq_pkg::PERCENT_W'(
                calibrated_percent(32'(raw_sample), 32'(dry_copy), 32'(wet_copy)));
            next_slot = (next_slot + 1) % QUEUE_DEPTH;
          end
        end else if (held_entries == 0) begin
          want.status = mphq_pkg::STATUS_EMPTY;
        end else begin
          want.percent = stored_percent[oldest_slot];
          oldest_slot = (oldest_slot + 1) % QUEUE_DEPTH;
          held_entries--;
        end
        want.fill_level = FILL_W'(held_entries);
        predicted_replies.push_back(want);
      end

      replies_owed <= predicted_replies.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int QUEUE_DEPTH   = 16;
  localparam int SAMPLE_BITS   = 12;
  localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  // overall limit for the whole run, generous for the transactions sent
  localparam int CYCLE_LIMIT   = 1000000;
  // settle time after the final drain, before the verdict
  localparam int SETTLE_CYCLES = 40;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic                   in_valid   = 1'b0;
  logic                   opcode     = mphq_pkg::OP_PUSH;
  logic [SAMPLE_BITS-1:0] raw_sample = '0;
  logic                   in_stall;

  // output channel
  logic                           out_stall  = 1'b0;
  logic                           out_valid;
  logic [1:0]                     status;
  logic [mphq_pkg::PERCENT_W-1:0] percent;
  logic [FILL_W-1:0]              fill_level;

  // calibration write port
  logic                   cfg_we     = 1'b0;
  logic                   cfg_index  = mphq_pkg::CFG_DRY_LEVEL;
  logic [SAMPLE_BITS-1:0] cfg_data   = '0;

  int          mismatch_count;
  int          replies_owed;
  int unsigned cycle_count = 0;

  // receiver stall pattern state
  int unsigned stall_left = 0;
  int unsigned quiet_left = 0;
  int unsigned stall_roll;

  // levels currently programmed, used to aim samples near the span edges
  logic [SAMPLE_BITS-1:0] dry_now = SAMPLE_BITS'(mphq_pkg::DRY_RESET);
  logic [SAMPLE_BITS-1:0] wet_now = SAMPLE_BITS'(mphq_pkg::WET_RESET);
  // when set the sender leaves no gaps between transactions
  bit steady_feed = 1'b0;

  always #5 clk = ~clk;

  moisture_percent_history_queue_unit #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .raw_sample (raw_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .percent    (percent),
    .fill_level (fill_level),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  moisture_history_monitor #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) monitor (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .raw_sample     (raw_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .percent        (percent),
    .fill_level     (fill_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .replies_owed   (replies_owed)
  );

  // hard stop in case the block hangs or a result never shows up
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall: mostly short bursts, a few long ones, and quiet stretches
  always @(posedge clk) begin
    if (quiet_left != 0) begin
      quiet_left--;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 2) begin
        quiet_left = $urandom_range(50, 300);
        out_stall <= 1'b0;
      end else if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 96) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  // sender gap after a transaction: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_feed || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample anywhere, at the rails, right around one of the levels, or inside the span
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned roll;
    int          near;
    roll = $urandom_range(0, 99);
    if (roll < 45) return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    if (roll < 55) return $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
    near = ($urandom_range(0, 1) ? int'(dry_now) : int'(wet_now))
           + int'($urandom_range(0, 6)) - 3;
    if (roll < 80) begin
      return (near < 0) ? '0 : ((near > SAMPLE_MAX) ? SAMPLE_BITS'(SAMPLE_MAX)
                                                     : SAMPLE_BITS'(near));
    end
    // inside the calibrated span
    return (dry_now < wet_now) ? SAMPLE_BITS'($urandom_range(int'(dry_now), int'(wet_now)))
                               : SAMPLE_BITS'($urandom_range(int'(wet_now), int'(dry_now)));
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic send(input logic op, input logic [SAMPLE_BITS-1:0] raw);
    int unsigned gap;
    in_valid <= 1'b1;
    opcode <= op;
    raw_sample <= raw;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every owed result to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  // program both calibration levels while nothing is in flight
  task automatic write_levels(input logic [SAMPLE_BITS-1:0] dry,
                              input logic [SAMPLE_BITS-1:0] wet);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= mphq_pkg::CFG_DRY_LEVEL;
    cfg_data <= dry;
    @(posedge clk);
    cfg_index <= mphq_pkg::CFG_WET_LEVEL;
    cfg_data <= wet;
    @(posedge clk);
    cfg_we <= 1'b0;
    dry_now = dry;
    wet_now = wet;
  endtask

  // random pushes and pops; the push share changes every few dozen so the
  // ring spends time empty, part full and overflowing
  task automatic random_run(input int unsigned count);
    int unsigned push_share;
    logic        op;
    push_share = 50;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: push_share = 20;
          1: push_share = 50;
          2: push_share = 80;
          default: push_share = 95;
        endcase
        steady_feed = ($urandom_range(0, 3) == 0);
      end
      op = ($urandom_range(0, 99) < push_share) ? mphq_pkg::OP_PUSH : mphq_pkg::OP_POP;
      send(op, pick_sample());
    end
    steady_feed = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset levels, dry above wet
    send(mphq_pkg::OP_POP, '0);                         // pop from an empty ring
    send(mphq_pkg::OP_PUSH, '0);                        // below both levels, clamps to wet
    send(mphq_pkg::OP_PUSH, SAMPLE_BITS'(SAMPLE_MAX));  // above both levels, clamps to dry
    send(mphq_pkg::OP_PUSH, 12'd2100);                  // mid span
    repeat (4) send(mphq_pkg::OP_POP, '0);              // drain, last one finds it empty
    // one more push than the ring holds, so the oldest gets overwritten
    for (int unsigned k = 0; k <= QUEUE_DEPTH; k++) begin
      send(mphq_pkg::OP_PUSH, SAMPLE_BITS'(k * 240));
    end
    random_run(300);

    // full range, rising
    write_levels('0, SAMPLE_BITS'(SAMPLE_MAX));
    random_run(250);

    // full range, falling
    write_levels(SAMPLE_BITS'(SAMPLE_MAX), '0);
    random_run(250);

    // equal levels: pushes are rejected, pops still drain what is held
    write_levels(12'd1000, 12'd1000);
    send(mphq_pkg::OP_PUSH, 12'd1000);
    random_run(150);

    // one-count span, steepest possible slope
    write_levels(12'd2047, 12'd2048);
    random_run(150);

    // both levels at the rails and equal
    write_levels(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
    random_run(80);
    write_levels('0, '0);
    random_run(80);

    // arbitrary calibrations
    repeat (3) begin
      write_levels(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                   SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
      random_run(80);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
